// ===== rtl/core/lsc_pkg.sv =====
`timescale 1ns / 1ps

package lsc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    REG_X_MIN,
    REG_Y_MIN,
    REG_X_END,
    REG_Y_END
  } reg_idx_e;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam int         PASS_BITS  = 4;
  localparam logic [3:0] MAX_PASSES = 4'd8;

  typedef struct packed {
    logic load;
    logic sel;
    logic mul;
    logic div_start;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic acc;
    logic rej;
    logic den_zero;
    logic div_done;
  } status_t;

endpackage

// ===== rtl/core/lsc_divider.sv =====
`timescale 1ns / 1ps

module lsc_divider #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2*COORD_BITS-1:0]   dividend_i,
  input  logic [COORD_BITS:0]       divisor_i,
  output logic [COORD_BITS-1:0]     quot_o,
  output logic                      done_o
);

  localparam int W     = COORD_BITS;
  localparam int STEPS = 2 * W;
  localparam int CW    = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic [W:0]       rem_q, rem_d;
  logic [STEPS-1:0] dq_q, dq_d;
  logic [W:0]       divisor_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [W+1:0]     shifted;
  logic [W+1:0]     diff;
  logic             ge;

  // One restoring step per cycle, quotient bits shift in at the bottom.
  always_comb begin
    shifted = {rem_q, dq_q[STEPS-1]};
    diff    = shifted - {1'b0, divisor_q};
    ge      = shifted >= {1'b0, divisor_q};
    rem_d   = ge ? diff[W:0] : shifted[W:0];
    dq_d    = {dq_q[STEPS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      dq_q      <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign quot_o = dq_q[W-1:0];
  assign done_o = done_q;

endmodule

// ===== rtl/core/lsc_ctrl.sv =====
`timescale 1ns / 1ps

module lsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output lsc_pkg::cmd_t    cmd_o,
  input  lsc_pkg::status_t st_i
);

  lsc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lsc_pkg::ST_CHECK;
        end
      end
      lsc_pkg::ST_CHECK: begin
        if (st_i.acc || st_i.rej || st_i.den_zero) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = lsc_pkg::ST_IDLE;
          end else begin
            state_d = lsc_pkg::ST_FIN;
          end
        end else begin
          cmd_o.sel = 1'b1;
          state_d   = lsc_pkg::ST_MUL;
        end
      end
      lsc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = lsc_pkg::ST_DSTART;
      end
      lsc_pkg::ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = lsc_pkg::ST_DIV;
      end
      lsc_pkg::ST_DIV: begin
        if (st_i.div_done) begin
          state_d = lsc_pkg::ST_UPD;
        end
      end
      lsc_pkg::ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = lsc_pkg::ST_CHECK;
      end
      lsc_pkg::ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = lsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/lsc_datapath.sv =====
`timescale 1ns / 1ps

module lsc_datapath #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsc_pkg::cmd_t                cmd_i,
  output lsc_pkg::status_t             st_o,
  input  logic signed [COORD_BITS-1:0] win_x_min_i,
  input  logic signed [COORD_BITS-1:0] win_y_min_i,
  input  logic signed [COORD_BITS-1:0] win_x_end_i,
  input  logic signed [COORD_BITS-1:0] win_y_end_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         accepted_o,
  output logic signed [COORD_BITS-1:0] clip_start_x_o,
  output logic signed [COORD_BITS-1:0] clip_start_y_o,
  output logic signed [COORD_BITS-1:0] clip_end_x_o,
  output logic signed [COORD_BITS-1:0] clip_end_y_o
);

  localparam int W = COORD_BITS;

  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W:0]   xmn,
    input logic signed [W:0]   ymn,
    input logic signed [W:0]   xmx,
    input logic signed [W:0]   ymx
  );
    logic [3:0]        c;
    logic signed [W:0] xe;
    logic signed [W:0] ye;
    c  = '0;
    xe = {x[W-1], x};
    ye = {y[W-1], y};
    if (xe < xmn) begin
      c = c | lsc_pkg::OC_LEFT;
    end else if (xe > xmx) begin
      c = c | lsc_pkg::OC_RIGHT;
    end
    if (ye < ymn) begin
      c = c | lsc_pkg::OC_BOTTOM;
    end else if (ye > ymx) begin
      c = c | lsc_pkg::OC_TOP;
    end
    return c;
  endfunction

  logic signed [W:0] xmin, ymin, xmax, ymax;

  assign xmin = {win_x_min_i[W-1], win_x_min_i};
  assign ymin = {win_y_min_i[W-1], win_y_min_i};
  assign xmax = {win_x_end_i[W-1], win_x_end_i} - {{W{1'b0}}, 1'b1};
  assign ymax = {win_y_end_i[W-1], win_y_end_i} - {{W{1'b0}}, 1'b1};

  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [W-1:0] ax_q, ay_q, bx_q, by_q;
  logic [3:0]          c0_q, c1_q;
  logic [lsc_pkg::PASS_BITS-1:0] pass_q;

  // Selection of the boundary and the crossing operands.
  logic [3:0]          co;
  logic                side_b;
  logic                vert;
  logic signed [W:0]   bound;
  logic signed [W-1:0] o0, o1, m0, m1;
  logic signed [W+1:0] num;
  logic signed [W:0]   den;
  logic signed [W:0]   mul;

  always_comb begin
    side_b = c1_q > c0_q;
    co     = side_b ? c1_q : c0_q;
    vert   = |(co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM));
    if (vert) begin
      bound = (|(co & lsc_pkg::OC_TOP)) ? ymax : ymin;
      o0    = y0_q;
      o1    = y1_q;
      m0    = x0_q;
      m1    = x1_q;
    end else begin
      bound = (|(co & lsc_pkg::OC_RIGHT)) ? xmax : xmin;
      o0    = x0_q;
      o1    = x1_q;
      m0    = y0_q;
      m1    = y1_q;
    end
    num = {bound[W], bound} - {{2{o0[W-1]}}, o0};
    den = {o1[W-1], o1} - {o0[W-1], o0};
    mul = {m1[W-1], m1} - {m0[W-1], m0};
  end

  logic signed [W+1:0] num_q;
  logic signed [W:0]   den_q, mul_q, bound_q;
  logic signed [W-1:0] base_q;
  logic                vert_q, side_q;

  logic [W+1:0]   num_neg;
  logic [W:0]     den_neg, mul_neg;
  logic [W:0]     num_mag, den_mag, mul_mag;
  logic [2*W+1:0] prod_full;

  always_comb begin
    num_neg   = -num_q;
    den_neg   = -den_q;
    mul_neg   = -mul_q;
    num_mag   = num_q[W+1] ? num_neg[W:0] : num_q[W:0];
    den_mag   = den_q[W] ? den_neg : den_q;
    mul_mag   = mul_q[W] ? mul_neg : mul_q;
    prod_full = {{(W+1){1'b0}}, mul_mag} * {{(W+1){1'b0}}, num_mag};
  end

  logic [2*W-1:0] prod_q;
  logic [W:0]     den_mag_q;
  logic           neg_q;
  logic [W-1:0]   quot;
  logic           div_done;

  lsc_divider #(
    .COORD_BITS (COORD_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_mag_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // Crossing point and its new outcode.
  logic [W-1:0]        qs;
  logic signed [W-1:0] v, bw, nx, ny;
  logic [3:0]          ncode;
  logic [3:0]          code_s, code_e;

  always_comb begin
    qs     = neg_q ? -quot : quot;
    v      = base_q + qs;
    bw     = bound_q[W-1:0];
    nx     = vert_q ? v : bw;
    ny     = vert_q ? bw : v;
    ncode  = outcode(nx, ny, xmin, ymin, xmax, ymax);
    code_s = outcode(start_x_i, start_y_i, xmin, ymin, xmax, ymax);
    code_e = outcode(end_x_i, end_y_i, xmin, ymin, xmax, ymax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q   <= '0;
      c1_q   <= '0;
      pass_q <= '0;
    end else if (cmd_i.load) begin
      c0_q   <= code_s;
      c1_q   <= code_e;
      pass_q <= '0;
    end else if (cmd_i.sel) begin
      pass_q <= pass_q + lsc_pkg::PASS_BITS'(1);
    end else if (cmd_i.upd) begin
      if (side_q) begin
        c1_q <= ncode;
      end else begin
        c0_q <= ncode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= start_x_i;
      y0_q <= start_y_i;
      x1_q <= end_x_i;
      y1_q <= end_y_i;
      ax_q <= start_x_i;
      ay_q <= start_y_i;
      bx_q <= end_x_i;
      by_q <= end_y_i;
    end
    if (cmd_i.sel) begin
      num_q   <= num;
      den_q   <= den;
      mul_q   <= mul;
      bound_q <= bound;
      base_q  <= m0;
      vert_q  <= vert;
      side_q  <= side_b;
    end
    if (cmd_i.mul) begin
      prod_q    <= prod_full[2*W-1:0];
      den_mag_q <= den_mag;
      neg_q     <= mul_q[W] ^ num_q[W+1] ^ den_q[W];
    end
    if (cmd_i.upd) begin
      if (side_q) begin
        bx_q <= nx;
        by_q <= ny;
      end else begin
        ax_q <= nx;
        ay_q <= ny;
      end
    end
  end

  logic acc;

  assign acc = (c0_q | c1_q) == 4'd0;

  always_comb begin
    st_o          = '0;
    st_o.acc      = acc;
    st_o.rej      = (|(c0_q & c1_q)) || (pass_q == lsc_pkg::MAX_PASSES);
    st_o.den_zero = den == '0;
    st_o.div_done = div_done;
  end

  logic                acc_out_q;
  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      acc_out_q <= acc;
      sx_q      <= acc ? ax_q : '1;
      sy_q      <= acc ? ay_q : '1;
      ex_q      <= acc ? bx_q : '1;
      ey_q      <= acc ? by_q : '1;
    end
  end

  assign accepted_o     = acc_out_q;
  assign clip_start_x_o = sx_q;
  assign clip_start_y_o = sy_q;
  assign clip_end_x_o   = ex_q;
  assign clip_end_y_o   = ey_q;

endmodule

// ===== rtl/core/line_segment_clipper.sv =====
`timescale 1ns / 1ps

// Line segment clipper with Cohen-Sutherland outcodes against a half-open window.
// The input channel (in_valid_i / in_ready_o) carries one request: a segment
// given by its start and end points. The output channel (out_valid_o / out_ready_i)
// returns one result per request: the clipped segment with accepted set, or all
// ones in every coordinate with accepted clear.
// The window bounds are written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle; the user is bound to this, the block itself does not enforce it.
// They reset to a minimum of 0 and an exclusive end of 32767.
// out_valid_o rises after the last clip pass of an accepted request, and the block
// is ready for the next request in that same cycle. A segment takes 0 to 8 clip
// passes, each dominated by the shared restoring divider, which retires one
// quotient bit per cycle.
// One request is processed at a time. A finished result sits in the output
// register, so a new request is accepted while the receiver stalls; if the
// next result finishes before the old one is taken, the block waits.
// Reset returns the controller to idle, drops out_valid_o and restores the
// window registers.

module line_segment_clipper #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic signed [COORD_BITS-1:0] clip_start_x_o,
  output logic signed [COORD_BITS-1:0] clip_start_y_o,
  output logic signed [COORD_BITS-1:0] clip_end_x_o,
  output logic signed [COORD_BITS-1:0] clip_end_y_o
);

  localparam int W = COORD_BITS;
  localparam logic [W-1:0] END_RESET = W'(32767);

  logic signed [W-1:0] win_x_min_q, win_y_min_q, win_x_end_q, win_y_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_min_q <= '0;
      win_y_min_q <= '0;
      win_x_end_q <= END_RESET;
      win_y_end_q <= END_RESET;
    end else if (cfg_we_i) begin
      unique case (lsc_pkg::reg_idx_e'(cfg_idx_i))
        lsc_pkg::REG_X_MIN: win_x_min_q <= cfg_data_i;
        lsc_pkg::REG_Y_MIN: win_y_min_q <= cfg_data_i;
        lsc_pkg::REG_X_END: win_x_end_q <= cfg_data_i;
        lsc_pkg::REG_Y_END: win_y_end_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lsc_pkg::cmd_t    cmd;
  lsc_pkg::status_t st;

  lsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  lsc_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .win_x_min_i    (win_x_min_q),
    .win_y_min_i    (win_y_min_q),
    .win_x_end_i    (win_x_end_q),
    .win_y_end_i    (win_y_end_q),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .accepted_o     (accepted_o),
    .clip_start_x_o (clip_start_x_o),
    .clip_start_y_o (clip_start_y_o),
    .clip_end_x_o   (clip_end_x_o),
    .clip_end_y_o   (clip_end_y_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int     CW             = 16;
  localparam int     CLK_PERIOD     = 10;
  localparam longint COORD_MIN      = -32768;
  localparam longint COORD_MAX      = 32767;
  localparam int     MAX_LATENCY    = 2 + 8 * (2 * CW + 5);
  localparam int     LONG_STALL     = 400;
  localparam int     WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } seg_t;

  typedef struct {
    logic          acc;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    int            passes;
    logic          limit_hit;
  } clip_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [1:0]            cfg_idx_i   = '0;
  logic [CW-1:0]         cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic signed [CW-1:0]  start_x_i   = '0;
  logic signed [CW-1:0]  start_y_i   = '0;
  logic signed [CW-1:0]  end_x_i     = '0;
  logic signed [CW-1:0]  end_y_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  accepted_o;
  logic signed [CW-1:0]  clip_start_x_o;
  logic signed [CW-1:0]  clip_start_y_o;
  logic signed [CW-1:0]  clip_end_x_o;
  logic signed [CW-1:0]  clip_end_y_o;

  logic signed [CW-1:0]  win_x_min = '0;
  logic signed [CW-1:0]  win_y_min = '0;
  logic signed [CW-1:0]  win_x_end = CW'(32767);
  logic signed [CW-1:0]  win_y_end = CW'(32767);

  seg_t  pending_q[$];
  clip_t expected_q[$];

  int idle_pct     = 31;
  int req_sent     = 0;
  int req_taken    = 0;
  int results_seen = 0;
  int n_errors     = 0;
  int n_windows    = 1;
  int n_inside     = 0;
  int n_rejected   = 0;
  int n_limit      = 0;
  int max_passes   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  logic stall_req  = 1'b0;
  logic stall_ack  = 1'b0;

  line_segment_clipper #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .clip_start_x_o(clip_start_x_o),
    .clip_start_y_o(clip_start_y_o),
    .clip_end_x_o  (clip_end_x_o),
    .clip_end_y_o  (clip_end_y_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint wrap_coord(longint v);
    logic signed [CW-1:0] t;
    t = v[CW-1:0];
    return t;
  endfunction

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < longint'(win_x_min)) begin
      c |= lsc_pkg::OC_LEFT;
    end else if (x > longint'(win_x_end) - 1) begin
      c |= lsc_pkg::OC_RIGHT;
    end
    if (y < longint'(win_y_min)) begin
      c |= lsc_pkg::OC_BOTTOM;
    end else if (y > longint'(win_y_end) - 1) begin
      c |= lsc_pkg::OC_TOP;
    end
    return c;
  endfunction

  // The crossing is always taken on the line through the original endpoints.
  function automatic clip_t clip_segment(seg_t s);
    longint x0, y0, x1, y1, ax, ay, bx, by, nx, ny, num, den, mul, base, v;
    logic [3:0] c0, c1, co;
    logic done;
    clip_t r;
    x0 = $signed(s.sx);
    y0 = $signed(s.sy);
    x1 = $signed(s.ex);
    y1 = $signed(s.ey);
    ax = x0;
    ay = y0;
    bx = x1;
    by = y1;
    c0 = region_code(ax, ay);
    c1 = region_code(bx, by);
    r.acc = 1'b0;
    r.passes = 0;
    r.limit_hit = 1'b0;
    done = 1'b0;
    while (!done) begin
      if ((c0 | c1) == 4'd0) begin
        r.acc = 1'b1;
        done = 1'b1;
      end else if ((c0 & c1) != 4'd0) begin
        done = 1'b1;
      end else if (r.passes >= int'(lsc_pkg::MAX_PASSES)) begin
        r.limit_hit = 1'b1;
        done = 1'b1;
      end else begin
        r.passes++;
        co = (c1 > c0) ? c1 : c0;
        if ((co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != 4'd0) begin
          ny = ((co & lsc_pkg::OC_TOP) != 4'd0) ? longint'(win_y_end) - 1
                                                : longint'(win_y_min);
          num = ny - y0;
          den = y1 - y0;
          mul = x1 - x0;
          base = x0;
        end else begin
          nx = ((co & lsc_pkg::OC_RIGHT) != 4'd0) ? longint'(win_x_end) - 1
                                                  : longint'(win_x_min);
          num = nx - x0;
          den = x1 - x0;
          mul = y1 - y0;
          base = y0;
        end
        if (den == 0) begin
          done = 1'b1;
        end else begin
          v = wrap_coord(base + mul * num / den);
          if ((co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != 4'd0) begin
            nx = v;
            ny = wrap_coord(ny);
          end else begin
            ny = v;
            nx = wrap_coord(nx);
          end
          if (co == c0) begin
            ax = nx;
            ay = ny;
            c0 = region_code(ax, ay);
          end else begin
            bx = nx;
            by = ny;
            c1 = region_code(bx, by);
          end
        end
      end
    end
    if (r.acc) begin
      r.sx = CW'(ax);
      r.sy = CW'(ay);
      r.ex = CW'(bx);
      r.ey = CW'(by);
    end else begin
      r.sx = '1;
      r.sy = '1;
      r.ex = '1;
      r.ey = '1;
    end
    return r;
  endfunction

  function automatic longint extreme_value(int unsigned k);
    case (k)
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [CW-1:0] random_coord(longint lo, longint hi);
    longint a, b, span;
    int unsigned pick;
    pick = $urandom_range(99);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = (b - a < 16) ? 16 : b - a;
    a = (a - span < COORD_MIN) ? COORD_MIN : a - span;
    b = (b + span > COORD_MAX) ? COORD_MAX : b + span;
    if (pick < 65) begin
      return CW'(a + longint'($urandom_range(int'(b - a))));
    end
    if (pick < 85) begin
      return CW'($urandom());
    end
    case ($urandom_range(5))
      0:       return CW'(lo);
      1:       return CW'(lo - 1);
      2:       return CW'(hi);
      3:       return CW'(hi - 1);
      default: return CW'(extreme_value($urandom_range(3)));
    endcase
  endfunction

  function automatic seg_t random_segment();
    seg_t s;
    int unsigned shape;
    s.sx = random_coord(win_x_min, win_x_end);
    s.sy = random_coord(win_y_min, win_y_end);
    s.ex = random_coord(win_x_min, win_x_end);
    s.ey = random_coord(win_y_min, win_y_end);
    shape = $urandom_range(99);
    if (shape < 8) begin
      s.ex = s.sx;
    end else if (shape < 16) begin
      s.ey = s.sy;
    end else if (shape < 19) begin
      s.ex = s.sx;
      s.ey = s.sy;
    end
    return s;
  endfunction

  task automatic pick_bounds(output longint lo, output longint hi);
    int unsigned kind;
    kind = $urandom_range(99);
    lo = COORD_MIN + longint'($urandom_range(65535));
    if (kind < 50) begin
      hi = lo + 1 + longint'($urandom_range(3000));
    end else if (kind < 70) begin
      hi = lo + 1 + longint'($urandom_range(2));
    end else if (kind < 85) begin
      hi = COORD_MIN + longint'($urandom_range(65535));
    end else begin
      lo = extreme_value($urandom_range(3));
      hi = extreme_value($urandom_range(3));
    end
    if (hi > COORD_MAX) begin
      hi = COORD_MAX;
    end
  endtask

  task automatic send_seg(longint sx, longint sy, longint ex, longint ey);
    seg_t s;
    s = '{CW'(sx), CW'(sy), CW'(ex), CW'(ey)};
    pending_q.insert(pending_q.size(), s);
  endtask

  task automatic send_random(int n);
    seg_t s;
    repeat (n) begin
      s = random_segment();
      pending_q.insert(pending_q.size(), s);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_q.size() != 0 || req_sent != req_taken || results_seen != req_taken);
  endtask

  task automatic write_reg(lsc_pkg::reg_idx_e idx, longint value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CW'(value);
  endtask

  // Only called with the block drained, so the window never changes under a request.
  task automatic write_window(longint xmin, longint ymin, longint xend, longint yend);
    write_reg(lsc_pkg::REG_X_MIN, xmin);
    write_reg(lsc_pkg::REG_Y_MIN, ymin);
    write_reg(lsc_pkg::REG_X_END, xend);
    write_reg(lsc_pkg::REG_Y_END, yend);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    win_x_min = CW'(xmin);
    win_y_min = CW'(ymin);
    win_x_end = CW'(xend);
    win_y_end = CW'(yend);
    n_windows++;
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_errors++;
    end
  endtask

  always @(negedge clk_i) begin
    if (req_sent == req_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        seg_t s;
        s = pending_q.pop_front();
        in_valid_i <= 1'b1;
        start_x_i  <= s.sx;
        start_y_i  <= s.sy;
        end_x_i    <= s.ex;
        end_y_i    <= s.ey;
        req_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_req != stall_ack) begin
      stall_ack  = stall_req;
      stall_left = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    clip_t want;
    if (in_valid_i && in_ready_o) begin
      want = clip_segment('{start_x_i, start_y_i, end_x_i, end_y_i});
      expected_q.insert(expected_q.size(), want);
      req_taken++;
      if (want.acc) begin
        n_inside++;
      end else begin
        n_rejected++;
      end
      if (want.limit_hit) begin
        n_limit++;
      end
      if (want.passes > max_passes) begin
        max_passes = want.passes;
      end
    end
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result without a pending request");
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("accepted", CW'(want.acc), CW'(accepted_o));
        check_field("clip_start_x", want.sx, clip_start_x_o);
        check_field("clip_start_y", want.sy, clip_start_y_o);
        check_field("clip_end_x", want.ex, clip_end_x_o);
        check_field("clip_end_y", want.ey, clip_end_y_o);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    longint xlo, xhi, ylo, yhi;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_seg(10, 10, 100, 200);
    send_seg(-5, -5, -10, -100);
    send_seg(-100, 50, 100, 50);
    send_seg(50, -100, 50, 100);
    send_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_seg(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_seg(COORD_MAX, 0, COORD_MAX, 100);
    send_seg(32766, 32766, 32766, 32766);
    send_seg(0, 0, 0, 0);
    send_seg(-1, -1, -1, -1);
    send_seg(-20000, 5000, 20000, -3000);
    send_seg(100, COORD_MIN, COORD_MIN, 100);
    wait_drained();

    write_window(-100, -50, 100, 60);
    send_seg(-200, 0, 200, 0);
    send_seg(0, -200, 0, 200);
    send_seg(-150, -150, 150, 150);
    send_seg(-150, 70, 150, -70);
    send_seg(99, 59, 100, 60);
    send_random(300);
    wait_drained();

    write_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    stall_req = ~stall_req;
    send_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_random(200);
    wait_drained();

    // A boundary of win_end - 1 wraps around here, so the moved endpoint never settles.
    write_window(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_seg(0, 0, COORD_MAX, 0);
    send_seg(COORD_MAX, 5, COORD_MIN, -7);
    send_random(150);
    wait_drained();

    write_window(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    idle_pct = 0;
    send_seg(0, 0, 0, COORD_MAX);
    send_random(100);
    wait_drained();
    idle_pct = 31;

    repeat (6) begin
      pick_bounds(xlo, xhi);
      pick_bounds(ylo, yhi);
      write_window(xlo, ylo, xhi, yhi);
      send_random(150);
      wait_drained();
    end

    repeat (MAX_LATENCY + 20) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      n_errors++;
    end
    $display("Clipped %0d segments under %0d window settings: %0d inside, %0d rejected.",
             req_taken, n_windows, n_inside, n_rejected);
    $display("%0d segments stopped at the pass limit; the deepest took %0d clip passes.",
             n_limit, max_passes);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
